[rtl/topr_pkg.sv]
// shared types and constants for the telnet option receive parser
// no dependencies; the other files but topr_if refer to it by scoped names

package topr_pkg;

  // subnegotiation byte counter saturates here
  localparam int SUBNEG_DEPTH = 16;
  localparam int SUB_LEN_W    = $clog2(SUBNEG_DEPTH + 1);
  localparam int NAWS_LEN     = 4;

  // job queue between parser and output sequencer
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] COLS_RST = 16'd80;
  localparam logic [15:0] ROWS_RST = 16'd25;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // option codes
  localparam logic [7:0] OP_ECHO  = 8'd1;
  localparam logic [7:0] OP_SGA   = 8'd3;
  localparam logic [7:0] OP_TTYPE = 8'd24;
  localparam logic [7:0] OP_NAWS  = 8'd31;
  localparam logic [7:0] OP_TSPD  = 8'd32;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_IAC    = 3'd1,
    ST_OPT    = 3'd2,
    ST_SB     = 3'd3,
    ST_OPTDAT = 3'd4,
    ST_SE     = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    BEAT_0 = 2'd0,
    BEAT_1 = 2'd1,
    BEAT_2 = 2'd2
  } beat_t;

  // one unit of output work: a data byte or a three-byte reply
  typedef struct packed {
    logic        is_reply;
    logic [7:0]  code;      // reply command byte
    logic [7:0]  byte_val;  // data byte, or option for a reply
    logic [15:0] cols;
    logic [15:0] rows;
  } job_t;

endpackage

[rtl/topr_if.sv]
// stream interfaces for the telnet option receive parser
// depends on nothing but the signal widths of the byte and result channels

interface topr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface topr_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [15:0] term_cols;
  logic [15:0] term_rows;

  modport source (output valid, output out_kind, output out_byte, output last,
                  output term_cols, output term_rows, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last,
                  input term_cols, input term_rows, output ready);
endinterface

[rtl/topr_front.sv]
// iac parser front end: accepts bytes, tracks option and subnegotiation state
// depends on topr_pkg and topr_in_if; emits jobs into the queue

module topr_front (
  input  logic                clk,
  input  logic                rst_n,
  topr_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output topr_pkg::job_t      push_job
);

  topr_pkg::parse_state_t             state_r, state_nxt;
  logic [7:0]                         option_r, option_nxt;
  logic [topr_pkg::SUB_LEN_W-1:0]     sub_len_r, sub_len_nxt;
  logic [7:0]                         sub_bytes_r [0:topr_pkg::NAWS_LEN-1];
  logic                               sub_wr;
  logic [15:0]                        cols_r, cols_nxt;
  logic [15:0]                        rows_r, rows_nxt;
  logic                               acc;
  logic [7:0]                         c;
  logic                               is_neg;
  logic                               peer_will;
  logic [15:0]                        naws_cols, naws_rows;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.rx_byte;
  assign is_neg      = (c == topr_pkg::B_WILL) || (c == topr_pkg::B_WONT) ||
                       (c == topr_pkg::B_DO)   || (c == topr_pkg::B_DONT);
  assign peer_will   = (option_r == topr_pkg::B_WILL) || (option_r == topr_pkg::B_WONT);
  assign naws_cols   = {sub_bytes_r[0], sub_bytes_r[1]};
  assign naws_rows   = {sub_bytes_r[2], sub_bytes_r[3]};

  // next state
  always_comb begin
    state_nxt = state_r;
    if (acc) begin
      unique case (state_r)
        topr_pkg::ST_IAC: begin
          if (is_neg) state_nxt = topr_pkg::ST_OPT;
          else if (c == topr_pkg::B_SB) state_nxt = topr_pkg::ST_SB;
          else state_nxt = topr_pkg::ST_NORMAL;
        end
        topr_pkg::ST_OPT:    state_nxt = topr_pkg::ST_NORMAL;
        topr_pkg::ST_SB:     state_nxt = topr_pkg::ST_OPTDAT;
        topr_pkg::ST_OPTDAT: begin
          if (c == topr_pkg::B_IAC) state_nxt = topr_pkg::ST_SE;
        end
        topr_pkg::ST_SE:     state_nxt = topr_pkg::ST_NORMAL;
        topr_pkg::ST_NORMAL: begin
          if (c == topr_pkg::B_IAC) state_nxt = topr_pkg::ST_IAC;
        end
        default:             state_nxt = topr_pkg::ST_NORMAL;
      endcase
    end
  end

  // outputs and datapath updates
  always_comb begin
    push              = 1'b0;
    push_job.is_reply = topr_pkg::KIND_DATA;
    push_job.code     = topr_pkg::B_DONT;
    push_job.byte_val = c;
    push_job.cols     = cols_r;
    push_job.rows     = rows_r;
    option_nxt        = option_r;
    sub_len_nxt       = sub_len_r;
    sub_wr            = 1'b0;
    cols_nxt          = cols_r;
    rows_nxt          = rows_r;
    if (acc) begin
      unique case (state_r)
        topr_pkg::ST_IAC: begin
          if (is_neg) option_nxt = c;
          else if (c == topr_pkg::B_IAC) push = 1'b1;
        end
        topr_pkg::ST_OPT: begin
          push_job.is_reply = topr_pkg::KIND_REPLY;
          if ((c == topr_pkg::OP_TTYPE) || (c == topr_pkg::OP_NAWS) ||
              (c == topr_pkg::OP_TSPD)) begin
            push          = 1'b1;
            push_job.code = topr_pkg::B_DO;
          end else if (c == topr_pkg::OP_ECHO) begin
            push = 1'b0;
          end else if (c == topr_pkg::OP_SGA) begin
            push          = 1'b1;
            push_job.code = peer_will ? topr_pkg::B_DO : topr_pkg::B_WILL;
          end else begin
            push          = 1'b1;
            push_job.code = peer_will ? topr_pkg::B_DONT : topr_pkg::B_WONT;
          end
        end
        topr_pkg::ST_SB: begin
          option_nxt  = c;
          sub_len_nxt = '0;
        end
        topr_pkg::ST_OPTDAT: begin
          if ((c != topr_pkg::B_IAC) &&
              (sub_len_r < topr_pkg::SUB_LEN_W'(topr_pkg::SUBNEG_DEPTH))) begin
            sub_wr      = (sub_len_r < topr_pkg::SUB_LEN_W'(topr_pkg::NAWS_LEN));
            sub_len_nxt = sub_len_r + topr_pkg::SUB_LEN_W'(1);
          end
        end
        topr_pkg::ST_SE: begin
          if ((c == topr_pkg::B_SE) && (option_r == topr_pkg::OP_NAWS) &&
              (sub_len_r == topr_pkg::SUB_LEN_W'(topr_pkg::NAWS_LEN))) begin
            if (naws_cols != '0) cols_nxt = naws_cols;
            if (naws_rows != '0) rows_nxt = naws_rows;
          end
        end
        default: begin
          if (c != topr_pkg::B_IAC) push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= topr_pkg::ST_NORMAL;
      option_r  <= '0;
      sub_len_r <= '0;
      cols_r    <= topr_pkg::COLS_RST;
      rows_r    <= topr_pkg::ROWS_RST;
    end else begin
      state_r   <= state_nxt;
      option_r  <= option_nxt;
      sub_len_r <= sub_len_nxt;
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
    end
  end

  // payload buffer, no reset
  always_ff @(posedge clk) begin
    if (sub_wr) sub_bytes_r[sub_len_r[$clog2(topr_pkg::NAWS_LEN)-1:0]] <= c;
  end

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc) else $error("job pushed without an accepted byte");

  a_sub_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    sub_len_r <= topr_pkg::SUB_LEN_W'(topr_pkg::SUBNEG_DEPTH))
    else $error("subnegotiation count past its limit");

  a_size_update_only_on_se: assert property (@(posedge clk) disable iff (!rst_n)
    (cols_r != $past(cols_r)) |-> ($past(state_r) == topr_pkg::ST_SE))
    else $error("column count changed outside end of subnegotiation");

endmodule

[rtl/topr_queue.sv]
// short job queue decoupling the parser from the output sequencer
// depends on topr_pkg for the job type and depth

module topr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  topr_pkg::job_t     push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output topr_pkg::job_t     head_job
);

  topr_pkg::job_t               mem_r [0:topr_pkg::Q_DEPTH-1];
  logic [topr_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [topr_pkg::Q_CW-1:0]    count_r;
  logic                         do_push, do_pop;

  assign full       = (count_r == topr_pkg::Q_CW'(topr_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + topr_pkg::Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + topr_pkg::Q_AW'(1);
      if (do_push && !do_pop)      count_r <= count_r + topr_pkg::Q_CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - topr_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full job queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= topr_pkg::Q_CW'(topr_pkg::Q_DEPTH)) else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with skewed pointers");

endmodule

[rtl/topr_back.sv]
// output sequencer: expands jobs into result beats behind an output register
// depends on topr_pkg and topr_out_if

module topr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  topr_pkg::job_t     head_job,
  output logic               pop,
  topr_out_if.source         out_ch
);

  topr_pkg::beat_t  beat_r, beat_nxt;
  logic             out_valid_r;
  logic             kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic [15:0]      cols_r, rows_r;
  logic             load;

  assign load = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    beat_nxt = beat_r;
    pop      = 1'b0;
    kind_nxt = head_job.is_reply;
    byte_nxt = head_job.byte_val;
    last_nxt = 1'b1;
    if (head_job.is_reply) begin
      unique case (beat_r)
        topr_pkg::BEAT_0: begin
          byte_nxt = topr_pkg::B_IAC;
          last_nxt = 1'b0;
        end
        topr_pkg::BEAT_1: begin
          byte_nxt = head_job.code;
          last_nxt = 1'b0;
        end
        default: begin
          byte_nxt = head_job.byte_val;
          last_nxt = 1'b1;
        end
      endcase
    end
    if (load) begin
      pop      = last_nxt;
      beat_nxt = last_nxt ? topr_pkg::BEAT_0 :
                 (beat_r == topr_pkg::BEAT_0) ? topr_pkg::BEAT_1 : topr_pkg::BEAT_2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= topr_pkg::BEAT_0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      cols_r <= head_job.cols;
      rows_r <= head_job.rows;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_kind  = kind_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.last      = last_r;
  assign out_ch.term_cols = cols_r;
  assign out_ch.term_rows = rows_r;

  a_mid_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != topr_pkg::BEAT_0) |-> (head_valid && head_job.is_reply))
    else $error("reply in progress without a reply job at queue head");

  a_beat_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (beat_r == topr_pkg::BEAT_2)) |=> (beat_r == topr_pkg::BEAT_0))
    else $error("beat counter did not wrap after final reply byte");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && last_r)) else $error("job retired before its last beat");

endmodule

[rtl/telnet_option_receive_parser_core.sv]
// top level of the telnet option receive parser
// depends on topr_pkg, topr_if, topr_front, topr_queue and topr_back
//
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      rx_byte[7:0]
//  out_ch    out   valid / ready      out_kind, out_byte[7:0], last, term_cols, term_rows
//
// one byte is accepted per cycle while the job queue has room; data bytes
// flow out at one per cycle while out_ch.ready stays high
// a reply passes through the output register as three beats, one per byte;
// the four-entry job queue absorbs bytes that arrive meanwhile
// a result is registered first in the job queue, then in the output register
// rst_n is synchronous and active low: parser to normal, size 80 x 25
// either side may stall on its own; in_ch.ready drops only when the queue fills

module telnet_option_receive_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  topr_in_if.sink     in_ch,
  topr_out_if.source  out_ch
);

  // parser to queue
  logic               push;
  topr_pkg::job_t     push_job;
  logic               q_full;

  // queue to output sequencer
  logic               pop;
  logic               head_valid;
  topr_pkg::job_t     head_job;

  // front end: iac state machine, option policy, naws capture
  topr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decoupling queue, jobs carry the terminal size seen at push time
  topr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back end: one beat per data job, three for a reply
  topr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
